// ===== sv/dmnf_pkg.sv =====
// ============================================================================
// dmnf_pkg - shared constants for the division magic number finder
// Field widths, stream packing and status codes.
// ============================================================================
package dmnf_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam int IN_FIELD_W = 32;
    localparam int MULT_W     = 32;
    localparam int SHIFT_W    = 6;
    localparam int STATUS_W   = 2;

    localparam int S_TDATA_W  = 2 * IN_FIELD_W;
    localparam int M_TDATA_W  = MULT_W + SHIFT_W + STATUS_W;

    // power-of-two trial value covers shifts 0..63
    localparam int E_W        = 64;
    localparam int SHIFT_MAX  = 63;

    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;

endpackage

// ===== sv/dmnf_csub.sv =====
// ============================================================================
// dmnf_csub - shared compare and subtract step
// Returns t - d when t >= d, else t; used for long division and residues.
// ============================================================================
module dmnf_csub
    import dmnf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic [DATA_WIDTH:0]   t,
    input  logic [DATA_WIDTH-1:0] d,
    output logic [DATA_WIDTH-1:0] res,
    output logic                  ge
);

    // when d <= t < 2d the true difference is below d, so the low bits suffice
    logic [DATA_WIDTH-1:0] diff;

    assign diff = t[DATA_WIDTH-1:0] - d;
    assign ge   = (t >= {1'b0, d});
    assign res  = ge ? diff : t[DATA_WIDTH-1:0];

endmodule

// ===== sv/division_magic_number_finder_top.sv =====
// ============================================================================
// division_magic_number_finder_top - magic multiplier and shift search
// Finds m, s so that n / d == (n * m) >> s for all n up to a given maximum.
// ============================================================================
// Usage:
//   Slave stream carries one request: largest numerator and divisor. Master
//   stream returns multiplier, shift amount and status for each request.
//   Only the low DATA_WIDTH bits of each input field are used.
// Timing:
//   One request at a time. After acceptance, a long division of nmax+1 by d
//   runs bit by bit on the shared compare/subtract step, a setup state
//   follows, then each trial shift does a registered multiply, then a
//   compare plus residue update. Divisor zero or one skips the division
//   and the search and goes straight to the result.
// Stall:
//   The result sits in an output register; a new request is taken while it
//   waits. A finished search holds in its last state until that register
//   is free.
// Reset:
//   rst_n clears the sequencer and the output valid; nothing else needs it.
// ============================================================================
module division_magic_number_finder_top
    import dmnf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] largest_numerator, [63:32] divisor
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] multiplier, [37:32] shift_amount, [39:38] status
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int W    = DATA_WIDTH;
    localparam int CW   = $clog2(W);
    localparam int NB_W = $clog2(W + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg,  state_next;
    logic [W-1:0]         d_reg,      d_next;
    logic [W-1:0]         np1_reg,    np1_next;
    logic [W-1:0]         nm1_reg,    nm1_next;
    logic [W-1:0]         rem_reg,    rem_next;
    logic [W-1:0]         nc_reg,     nc_next;
    logic [W-1:0]         q_reg,      q_next;
    logic [E_W-1:0]       e_reg,      e_next;
    logic [SHIFT_W-1:0]   s_reg,      s_next;
    logic [SHIFT_W-1:0]   limit_reg,  limit_next;
    logic [NB_W-1:0]      nbits_reg,  nbits_next;
    logic [CW-1:0]        cnt_reg,    cnt_next;
    logic [2*W-1:0]       prod_reg,   prod_next;
    logic [W-1:0]         rmult_reg,  rmult_next;
    logic [SHIFT_W-1:0]   rshift_reg, rshift_next;
    logic [STATUS_W-1:0]  rstat_reg,  rstat_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    logic [W-1:0]   in_nmax;
    logic [W-1:0]   in_d;
    logic [W:0]     cs_t;
    logic [W-1:0]   cs_res;
    logic           cs_ge;
    logic [W-1:0]   mod_val;
    logic [NB_W:0]  nb2;
    logic           s_acc;
    logic           out_free;

    assign in_nmax  = s_tdata[W-1:0];
    assign in_d     = s_tdata[IN_FIELD_W +: W];
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign mod_val  = d_reg - rem_reg - W'(1);
    assign nb2      = {nbits_reg, 1'b0};
    assign cs_t     = (state_reg == ST_DIV) ? {rem_reg, np1_reg[W-1]} : {rem_reg, 1'b1};

    dmnf_csub #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_csub (
        .t   (cs_t),
        .d   (d_reg),
        .res (cs_res),
        .ge  (cs_ge)
    );

    always_comb
    begin
        state_next    = state_reg;
        d_next        = d_reg;
        np1_next      = np1_reg;
        nm1_next      = nm1_reg;
        rem_next      = rem_reg;
        nc_next       = nc_reg;
        q_next        = q_reg;
        e_next        = e_reg;
        s_next        = s_reg;
        limit_next    = limit_reg;
        nbits_next    = nbits_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        rmult_next    = rmult_reg;
        rshift_next   = rshift_reg;
        rstat_next    = rstat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    d_next      = in_d;
                    np1_next    = in_nmax + W'(1);
                    nm1_next    = (in_nmax > W'(1)) ? in_nmax - W'(1) : '0;
                    rem_next    = '0;
                    nbits_next  = '0;
                    cnt_next    = CW'(W - 1);
                    rshift_next = '0;
                    if (in_d == '0)
                    begin
                        rmult_next = '1;
                        rstat_next = ST_DIVZERO;
                        state_next = ST_DONE;
                    end
                    else if (in_d == W'(1))
                    begin
                        rmult_next = W'(1);
                        rstat_next = ST_FOUND;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = cs_res;
                np1_next = {np1_reg[W-2:0], np1_reg[W-1]};
                nm1_next = {nm1_reg[W-2:0], 1'b0};
                if ((nbits_reg == '0) && nm1_reg[W-1])
                    nbits_next = NB_W'(cnt_reg) + NB_W'(1);
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                nc_next  = np1_reg - rem_reg - W'(1);
                rem_next = '0;
                q_next   = '0;
                e_next   = E_W'(1);
                s_next   = '0;
                if (nb2 > (NB_W+1)'(SHIFT_MAX))
                    limit_next = SHIFT_W'(SHIFT_MAX);
                else
                    limit_next = SHIFT_W'(nb2);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = nc_reg * mod_val;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (E_W'(prod_reg) < e_reg)
                begin
                    rmult_next  = q_reg + W'(1);
                    rshift_next = s_reg;
                    rstat_next  = ST_FOUND;
                    state_next  = ST_DONE;
                end
                else if (s_reg == limit_reg)
                begin
                    rmult_next  = '1;
                    rshift_next = '0;
                    rstat_next  = ST_NONE;
                    state_next  = ST_DONE;
                end
                else
                begin
                    rem_next   = cs_res;
                    q_next     = {q_reg[W-2:0], cs_ge};
                    e_next     = {e_reg[E_W-2:0], 1'b0};
                    s_next     = s_reg + SHIFT_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rstat_reg, rshift_reg, MULT_W'(rmult_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        np1_reg     <= np1_next;
        nm1_reg     <= nm1_next;
        rem_reg     <= rem_next;
        nc_reg      <= nc_next;
        q_reg       <= q_next;
        e_reg       <= e_next;
        s_reg       <= s_next;
        limit_reg   <= limit_next;
        nbits_reg   <= nbits_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        rmult_reg   <= rmult_next;
        rshift_reg  <= rshift_next;
        rstat_reg   <= rstat_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // residue stays below the divisor through the shift search
    a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_CMP) |-> (rem_reg < d_reg))
        else $error("residue not below divisor");

    // trial shift never passes its limit
    a_shift_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_CMP) |-> (s_reg <= limit_reg))
        else $error("trial shift beyond limit");

    // trial power of two stays one-hot
    a_e_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_CMP) |-> $onehot(e_reg))
        else $error("trial power not one-hot");

    // a fresh result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");

    // failure codes always carry shift zero
    a_fail_shift_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[M_TDATA_W-1 -: STATUS_W] != ST_FOUND))
        |-> (m_tdata[MULT_W +: SHIFT_W] == '0))
        else $error("nonzero shift on failure status");

endmodule
